### rtl/core/cpct_pkg.sv
// ----------------------------------------------------------------------------
// cpct_pkg
// Types and constants shared by the collider pair contact tracker.
// ----------------------------------------------------------------------------
package cpct_pkg;

    // Shape kinds.
    localparam logic [1:0] KIND_RECT   = 2'd0;
    localparam logic [1:0] KIND_CIRCLE = 2'd1;

    // Contact event codes.
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_ENTER = 2'd1;
    localparam logic [1:0] EV_STAY  = 2'd2;
    localparam logic [1:0] EV_EXIT  = 2'd3;

    // Geometry widths in units of 1/512.
    localparam int GEO_W = 28;
    localparam int MAG_W = 27;
    localparam int RAD_W = 25;
    localparam int SQ_W  = 2 * MAG_W;
    localparam int ACC_W = SQ_W + 1;

    typedef struct packed {
        logic [31:0]        left_id;
        logic [31:0]        right_id;
        logic [1:0]         left_kind;
        logic [1:0]         right_kind;
        logic signed [23:0] left_x;
        logic signed [23:0] left_y;
        logic [15:0]        left_w;
        logic [15:0]        left_h;
        logic signed [23:0] right_x;
        logic signed [23:0] right_y;
        logic [15:0]        right_w;
        logic [15:0]        right_h;
    } pair_item_t;

    typedef struct packed {
        logic [1:0] contact_event;
        logic       overlapping;
        logic       table_full;
    } event_item_t;

    // One table slot.
    typedef struct packed {
        logic        valid;
        logic        contact;
        logic [63:0] key;
    } slot_t;

endpackage

### rtl/core/cpct_if.sv
// ----------------------------------------------------------------------------
// cpct_if
// Valid/ready channels for collider pairs and contact events.
// ----------------------------------------------------------------------------
interface cpct_pair_if import cpct_pkg::*; ();
    logic       valid;
    logic       ready;
    pair_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cpct_event_if import cpct_pkg::*; ();
    logic        valid;
    logic        ready;
    event_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/core/cpct_overlap.sv
// ----------------------------------------------------------------------------
// cpct_overlap
// Multi-cycle shape overlap test with one shared squaring multiplier.
// ----------------------------------------------------------------------------
module cpct_overlap import cpct_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  pair_item_t item,
    output logic       done,
    output logic       hit
);

    localparam logic [2:0] GS_IDLE = 3'd0;
    localparam logic [2:0] GS_PREP = 3'd1;
    localparam logic [2:0] GS_DIFF = 3'd2;
    localparam logic [2:0] GS_SQX  = 3'd3;
    localparam logic [2:0] GS_SQY  = 3'd4;
    localparam logic [2:0] GS_SQR  = 3'd5;
    localparam logic [2:0] GS_CMP  = 3'd6;

    function automatic logic signed [GEO_W-1:0] dbl(input logic signed [23:0] p);
        return {{(GEO_W-25){p[23]}}, p, 1'b0};
    endfunction

    function automatic logic signed [GEO_W-1:0] scale100(input logic [16:0] s);
        logic [GEO_W-1:0] t;
        t = {{(GEO_W-17){1'b0}}, s} * GEO_W'(100);
        return signed'(t);
    endfunction

    function automatic logic [GEO_W-1:0] absv(input logic signed [GEO_W-1:0] v);
        logic signed [GEO_W-1:0] a;
        a = (v < 0) ? -v : v;
        return unsigned'(a);
    endfunction

    logic [2:0]              step_reg;
    pair_item_t              item_reg;
    logic                    rr_reg, round_reg;
    logic signed [GEO_W-1:0] mx_reg, my_reg, lox_reg, hix_reg, loy_reg, hiy_reg;
    logic signed [GEO_W-1:0] rdx_reg, rdy_reg, rsx_reg, rsy_reg;
    logic [RAD_W-1:0]        rad_reg;
    logic                    rr_hit_reg;
    logic [MAG_W-1:0]        magx_reg, magy_reg;
    logic [SQ_W-1:0]         prod_reg;
    logic [ACC_W-1:0]        acc_reg;

    // Operand selection: circle first, the other shape second.
    logic                    is_rr, is_cc, is_cr, is_rc;
    logic signed [23:0]      cx, cy, ox, oy;
    logic [15:0]             cw, ch, ow, oh;
    logic signed [GEO_W-1:0] octr_x, octr_y, px, py;
    logic [MAG_W-1:0]        mul_a;

    always_comb
    begin
        is_rr = (item_reg.left_kind == KIND_RECT) && (item_reg.right_kind == KIND_RECT);
        is_cc = (item_reg.left_kind == KIND_CIRCLE) && (item_reg.right_kind == KIND_CIRCLE);
        is_cr = (item_reg.left_kind == KIND_CIRCLE) && (item_reg.right_kind == KIND_RECT);
        is_rc = (item_reg.left_kind == KIND_RECT) && (item_reg.right_kind == KIND_CIRCLE);
        cx = is_rc ? item_reg.right_x : item_reg.left_x;
        cy = is_rc ? item_reg.right_y : item_reg.left_y;
        cw = is_rc ? item_reg.right_w : item_reg.left_w;
        ch = is_rc ? item_reg.right_h : item_reg.left_h;
        ox = is_rc ? item_reg.left_x : item_reg.right_x;
        oy = is_rc ? item_reg.left_y : item_reg.right_y;
        ow = is_rc ? item_reg.left_w : item_reg.right_w;
        oh = is_rc ? item_reg.left_h : item_reg.right_h;
        octr_x = dbl(ox) + scale100({1'b0, ow});
        octr_y = dbl(oy) + scale100({1'b0, oh});

        // Clamp the circle centre into the other span; a circle pair uses a point span.
        px = mx_reg;
        if (mx_reg > hix_reg) px = hix_reg;
        if (mx_reg < lox_reg) px = lox_reg;
        py = my_reg;
        if (my_reg > hiy_reg) py = hiy_reg;
        if (my_reg < loy_reg) py = loy_reg;

        case (step_reg)
            GS_SQX:  mul_a = magx_reg;
            GS_SQY:  mul_a = magy_reg;
            default: mul_a = {{(MAG_W-RAD_W){1'b0}}, rad_reg};
        endcase
    end

    // Step sequencer and datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= GS_IDLE;
        end
        else
        begin
            case (step_reg)
                GS_IDLE: if (start) step_reg <= GS_PREP;
                GS_CMP:  step_reg <= GS_IDLE;
                default: step_reg <= step_reg + 3'd1;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (step_reg)
            GS_IDLE:
            begin
                if (start) item_reg <= item;
            end
            GS_PREP:
            begin
                rr_reg    <= is_rr;
                round_reg <= is_cc || is_cr || is_rc;
                mx_reg    <= dbl(cx) + scale100({1'b0, cw});
                my_reg    <= dbl(cy) + scale100({1'b0, ch});
                lox_reg   <= is_cc ? octr_x : dbl(ox);
                loy_reg   <= is_cc ? octr_y : dbl(oy);
                hix_reg   <= is_cc ? octr_x : dbl(ox) + (scale100({1'b0, ow}) <<< 1);
                hiy_reg   <= is_cc ? octr_y : dbl(oy) + (scale100({1'b0, oh}) <<< 1);
                rad_reg   <= is_cc
                    ? RAD_W'(scale100({1'b0, item_reg.left_w} + {1'b0, item_reg.right_w}))
                    : RAD_W'(scale100({1'b0, cw}));
                rdx_reg   <= dbl(item_reg.left_x) - dbl(item_reg.right_x);
                rdy_reg   <= dbl(item_reg.left_y) - dbl(item_reg.right_y);
                rsx_reg   <= scale100({1'b0, item_reg.left_w} + {1'b0, item_reg.right_w});
                rsy_reg   <= scale100({1'b0, item_reg.left_h} + {1'b0, item_reg.right_h});
            end
            GS_DIFF:
            begin
                magx_reg   <= MAG_W'(absv(mx_reg - px));
                magy_reg   <= MAG_W'(absv(my_reg - py));
                rr_hit_reg <= (absv(rdx_reg) < unsigned'(rsx_reg))
                           && (absv(rdy_reg) < unsigned'(rsy_reg));
            end
            default:
            begin
            end
        endcase

        // Squares: x, then y, then radius; the x and y products join the sum in the cycle after they are registered.
        prod_reg <= SQ_W'(mul_a) * SQ_W'(mul_a);
        if (step_reg == GS_SQY) acc_reg <= ACC_W'(prod_reg);
        if (step_reg == GS_SQR) acc_reg <= acc_reg + ACC_W'(prod_reg);
    end

    assign done = (step_reg == GS_CMP);
    assign hit  = rr_reg ? rr_hit_reg : (round_reg && (acc_reg <= ACC_W'(prod_reg)));

endmodule

### rtl/core/collider_pair_contact_tracker.sv
// ----------------------------------------------------------------------------
// collider_pair_contact_tracker
// Shape overlap test plus per-pair contact memory giving enter/stay/exit.
// ----------------------------------------------------------------------------
// One pair is handled at a time. Each table probe is a synchronous read
// followed by a key compare, and the overlap test runs alongside the probe.
// The event is registered once both the probe and the overlap test are done,
// and the next pair can be taken once the event is registered. A probe goes
// on slot by slot until it meets a free slot or the pair's key, or until the
// whole table has been searched. A stalled event output holds the finished
// pair until the output is free.
// After reset the slot memory is swept clear, one slot per cycle, before
// the first pair is accepted.
module collider_pair_contact_tracker import cpct_pkg::*; #(
    parameter int PAIR_SLOTS = 256
) (
    input logic          clk,
    input logic          rst_n,
    cpct_pair_if.sink    pairs,
    cpct_event_if.source events
);

    localparam int IDX_W = $clog2(PAIR_SLOTS);
    localparam int CNT_W = $clog2(PAIR_SLOTS + 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_CHECK = 3'd3;
    localparam logic [2:0] ST_WAIT  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] addr_reg, addr_next;
    logic [CNT_W-1:0] probe_reg, probe_next;
    logic             found_reg, found_next;
    logic             prior_reg, prior_next;
    logic             hit_reg, hit_next;
    logic             geo_ok_reg, geo_ok_next;
    logic             out_valid_reg, out_valid_next;
    event_item_t      out_data_reg, out_data_next;
    pair_item_t       item_reg;

    slot_t            mem [PAIR_SLOTS];
    slot_t            rdata_reg;
    slot_t            wdata;
    logic             we;

    logic             accept;
    logic             geo_done, geo_hit;
    logic [IDX_W:0]   start_raw;
    logic [IDX_W-1:0] start_idx, addr_inc;
    logic [63:0]      key;
    logic             out_free;

    cpct_overlap u_overlap (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .item  (pairs.data),
        .done  (geo_done),
        .hit   (geo_hit)
    );

    // Slot memory: one write port, registered read of the probe address.
    always_ff @(posedge clk)
    begin
        if (we) mem[addr_reg] <= wdata;
        rdata_reg <= mem[addr_reg];
    end

    // Probe start and wrap.
    always_comb
    begin
        start_raw = {1'b0, pairs.data.right_id[IDX_W-1:0]};
        if (start_raw >= (IDX_W+1)'(PAIR_SLOTS))
            start_idx = IDX_W'(start_raw - (IDX_W+1)'(PAIR_SLOTS));
        else
            start_idx = start_raw[IDX_W-1:0];
        addr_inc = (addr_reg == IDX_W'(PAIR_SLOTS - 1)) ? '0 : addr_reg + 1'b1;
        key = {item_reg.left_id, item_reg.right_id};
    end

    assign accept       = pairs.valid && pairs.ready;
    assign pairs.ready  = (state_reg == ST_IDLE);
    assign events.valid = out_valid_reg;
    assign events.data  = out_data_reg;
    assign out_free     = !out_valid_reg || events.ready;

    // Control sequencer.
    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        probe_next     = probe_reg;
        found_next     = found_reg;
        prior_next     = prior_reg;
        hit_next       = hit_reg;
        geo_ok_next    = geo_ok_reg;
        out_valid_next = out_valid_reg && !events.ready;
        out_data_next  = out_data_reg;
        we             = 1'b0;
        wdata          = '0;

        if (geo_done)
        begin
            hit_next    = geo_hit;
            geo_ok_next = 1'b1;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                we = 1'b1;
                addr_next = addr_inc;
                if (addr_reg == IDX_W'(PAIR_SLOTS - 1)) state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    addr_next   = start_idx;
                    probe_next  = '0;
                    geo_ok_next = 1'b0;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (!rdata_reg.valid)
                begin
                    found_next = 1'b1;
                    prior_next = 1'b0;
                    state_next = ST_WAIT;
                end
                else if (rdata_reg.key == key)
                begin
                    found_next = 1'b1;
                    prior_next = rdata_reg.contact;
                    state_next = ST_WAIT;
                end
                else if (probe_reg == CNT_W'(PAIR_SLOTS - 1))
                begin
                    found_next = 1'b0;
                    prior_next = 1'b0;
                    state_next = ST_WAIT;
                end
                else
                begin
                    probe_next = probe_reg + 1'b1;
                    addr_next  = addr_inc;
                    state_next = ST_READ;
                end
            end
            ST_WAIT:
            begin
                if (geo_ok_reg) state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    we    = found_reg;
                    wdata = '{valid: 1'b1, contact: hit_reg, key: key};
                    if (hit_reg)
                        out_data_next.contact_event = prior_reg ? EV_STAY : EV_ENTER;
                    else
                        out_data_next.contact_event = prior_reg ? EV_EXIT : EV_NONE;
                    out_data_next.overlapping = hit_reg;
                    out_data_next.table_full  = !found_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            addr_reg      <= '0;
            probe_reg     <= '0;
            found_reg     <= 1'b0;
            prior_reg     <= 1'b0;
            geo_ok_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            probe_reg     <= probe_next;
            found_reg     <= found_next;
            prior_reg     <= prior_next;
            geo_ok_reg    <= geo_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        hit_reg      <= hit_next;
        out_data_reg <= out_data_next;
        if (accept) item_reg <= pairs.data;
    end

`ifndef NO_ASSERTIONS
    a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !out_valid_reg)
        else $error("result presented during memory sweep");

    a_full_no_prior: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.table_full |->
            (out_data_reg.contact_event == EV_NONE || out_data_reg.contact_event == EV_ENTER))
        else $error("unstored pair reported a prior contact");

    a_event_matches_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_data_reg.overlapping ==
            (out_data_reg.contact_event == EV_ENTER || out_data_reg.contact_event == EV_STAY))
        else $error("event code disagrees with overlap flag");

    a_geo_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        geo_done |-> (state_reg == ST_READ || state_reg == ST_CHECK || state_reg == ST_WAIT))
        else $error("overlap result arrived with no pair in flight");
`endif

endmodule

### sim/cpct_event_checker.sv
// ----------------------------------------------------------------------------
// cpct_event_checker
// Watches the pair and event channels of the contact tracker, predicts the
// event for every accepted pair and compares it with the returned events.
// ----------------------------------------------------------------------------
module cpct_event_checker import cpct_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    cpct_pair_if  pairs,
    cpct_event_if events,
    output int    mismatches,
    output int    pending
);

    // Contact memory of the predictor, keyed by the 64-bit pair key.
    bit          contact_by_key [bit [63:0]];
    int          stored_pairs;
    event_item_t expected_events [$];

    // Circle at (cx, cy) with diameter cw against a rectangle with its corner at (rx, ry).
    function automatic bit circle_hits_rect(longint cx, longint cy, longint cw, longint ch,
                                            longint rx, longint ry, longint rw, longint rh);
        longint mx;
        longint my;
        longint px;
        longint py;
        mx = cx + 100 * cw;
        my = cy + 100 * ch;
        px = (mx > rx + 200 * rw) ? rx + 200 * rw : mx;
        px = (px < rx) ? rx : px;
        py = (my > ry + 200 * rh) ? ry + 200 * rh : my;
        py = (py < ry) ? ry : py;
        return (mx - px) * (mx - px) + (my - py) * (my - py) <= (100 * cw) * (100 * cw);
    endfunction

    // Shape test in units of 1/512, so every half size is a whole number.
    function automatic bit shapes_overlap(pair_item_t p);
        longint lx;
        longint ly;
        longint rx;
        longint ry;
        longint lw;
        longint lh;
        longint rw;
        longint rh;
        longint dx;
        longint dy;
        longint dx_mag;
        longint dy_mag;
        lx = 2 * longint'(p.left_x);
        ly = 2 * longint'(p.left_y);
        rx = 2 * longint'(p.right_x);
        ry = 2 * longint'(p.right_y);
        lw = longint'(p.left_w);
        lh = longint'(p.left_h);
        rw = longint'(p.right_w);
        rh = longint'(p.right_h);
        if (p.left_kind == KIND_RECT && p.right_kind == KIND_RECT)
        begin
            dx_mag = (lx > rx) ? lx - rx : rx - lx;
            dy_mag = (ly > ry) ? ly - ry : ry - ly;
            return dx_mag < 100 * (lw + rw) && dy_mag < 100 * (lh + rh);
        end
        if (p.left_kind == KIND_CIRCLE && p.right_kind == KIND_CIRCLE)
        begin
            dx = (lx + 100 * lw) - (rx + 100 * rw);
            dy = (ly + 100 * lh) - (ry + 100 * rh);
            return dx * dx + dy * dy <= (100 * (lw + rw)) * (100 * (lw + rw));
        end
        if (p.left_kind == KIND_CIRCLE && p.right_kind == KIND_RECT)
            return circle_hits_rect(lx, ly, lw, lh, rx, ry, rw, rh);
        if (p.left_kind == KIND_RECT && p.right_kind == KIND_CIRCLE)
            return circle_hits_rect(rx, ry, rw, rh, lx, ly, lw, lh);
        // Any other combination of kinds never intersects.
        return 1'b0;
    endfunction

    // Event for one pair; updates the contact memory as the block does.
    function automatic event_item_t contact_event_of(pair_item_t p);
        event_item_t ev;
        bit [63:0]   key;
        bit          known;
        bit          prior;
        key   = {p.left_id, p.right_id};
        ev    = '0;
        prior = 1'b0;
        ev.overlapping = shapes_overlap(p);
        known = contact_by_key.exists(key);
        if (!known && stored_pairs < 256)
        begin
            // A new pair is stored without contact, even when it misses.
            contact_by_key[key] = 1'b0;
            stored_pairs++;
            known = 1'b1;
        end
        else if (!known)
        begin
            ev.table_full = 1'b1;
        end
        if (known)
            prior = contact_by_key[key];
        if (ev.overlapping)
        begin
            ev.contact_event = prior ? EV_STAY : EV_ENTER;
            if (known)
                contact_by_key[key] = 1'b1;
        end
        else if (prior)
        begin
            ev.contact_event = EV_EXIT;
            contact_by_key[key] = 1'b0;
        end
        else
        begin
            ev.contact_event = EV_NONE;
        end
        return ev;
    endfunction

    assign pending = expected_events.size();

    // Predict on every pair transfer and compare on every event transfer.
    always @(posedge clk or negedge rst_n)
    begin
        event_item_t want;
        if (!rst_n)
        begin
            mismatches <= 0;
            stored_pairs = 0;
        end
        else
        begin
            if (pairs.valid && pairs.ready)
                expected_events.push_back(contact_event_of(pairs.data));
            if (events.valid && events.ready)
            begin
                if (expected_events.size() == 0)
                begin
                    $display("%0t: unexpected event: expected none, actual %0d/%0b/%0b",
                             $time, events.data.contact_event, events.data.overlapping,
                             events.data.table_full);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (want !== events.data)
                    begin
                        $display("%0t: event mismatch: expected %0d/%0b/%0b, actual %0d/%0b/%0b",
                                 $time, want.contact_event, want.overlapping, want.table_full,
                                 events.data.contact_event, events.data.overlapping,
                                 events.data.table_full);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end

endmodule

### sim/tb_collider_pair_contact_tracker.sv
// ----------------------------------------------------------------------------
// tb_collider_pair_contact_tracker
// Drives collider pairs into the contact tracker under several idle and
// stall patterns, fills the pair table until it overflows, and reports the
// verdict of the event checker.
// ----------------------------------------------------------------------------
module tb_collider_pair_contact_tracker;
    import cpct_pkg::*;

    localparam int POOL_SIZE   = 48;
    localparam int CYCLE_LIMIT = 3000000;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   pending;
    int   send_idle;
    int   recv_stall;
    int   hold_request;
    int   fresh_count;
    logic [31:0] pool_left  [POOL_SIZE];
    logic [31:0] pool_right [POOL_SIZE];

    cpct_pair_if  pairs ();
    cpct_event_if events ();

    collider_pair_contact_tracker u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .pairs  (pairs),
        .events (events)
    );

    cpct_event_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .pairs      (pairs),
        .events     (events),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Some tests failed");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off on request.
    initial
    begin
        int hold_left;
        events.ready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                events.ready <= 1'b0;
            end
            else
            begin
                events.ready <= ($urandom_range(99) >= recv_stall);
            end
        end
    end

    // One pair transfer, after a random number of idle cycles.
    task automatic send_pair(pair_item_t item);
        while ($urandom_range(99) < send_idle)
        begin
            pairs.valid <= 1'b0;
            @(posedge clk);
        end
        pairs.valid <= 1'b1;
        pairs.data  <= item;
        @(posedge clk);
        while (!pairs.ready)
            @(posedge clk);
    endtask

    // Random geometry near each other, so overlaps come and go.
    function automatic pair_item_t random_geometry(logic [31:0] lid, logic [31:0] rid);
        pair_item_t p;
        int base_x;
        int base_y;
        p.left_id  = lid;
        p.right_id = rid;
        if ($urandom_range(9) == 0)
        begin
            p.left_kind  = 2'($urandom_range(3));
            p.right_kind = 2'($urandom_range(3));
        end
        else
        begin
            p.left_kind  = 2'($urandom_range(1));
            p.right_kind = 2'($urandom_range(1));
        end
        if ($urandom_range(19) == 0)
        begin
            // Noise over the whole range of every field.
            p.left_x  = 24'($urandom);
            p.left_y  = 24'($urandom);
            p.right_x = 24'($urandom);
            p.right_y = 24'($urandom);
            p.left_w  = 16'($urandom);
            p.left_h  = 16'($urandom);
            p.right_w = 16'($urandom);
            p.right_h = 16'($urandom);
        end
        else
        begin
            base_x = int'($urandom_range(16000000)) - 8000000;
            base_y = int'($urandom_range(16000000)) - 8000000;
            p.left_x  = 24'(base_x);
            p.left_y  = 24'(base_y);
            p.right_x = 24'(base_x + int'($urandom_range(4000)) - 2000);
            p.right_y = 24'(base_y + int'($urandom_range(4000)) - 2000);
            p.left_w  = 16'($urandom_range(40));
            p.left_h  = 16'($urandom_range(40));
            p.right_w = 16'($urandom_range(40));
            p.right_h = 16'($urandom_range(40));
        end
        return p;
    endfunction

    function automatic pair_item_t shaped_pair(logic [31:0] lid, logic [31:0] rid,
                                               logic [1:0] lk, logic [1:0] rk,
                                               int lx, int ly, int lw, int lh,
                                               int rx, int ry, int rw, int rh);
        pair_item_t p;
        p = '{left_id: lid, right_id: rid, left_kind: lk, right_kind: rk,
              left_x: 24'(lx), left_y: 24'(ly), left_w: 16'(lw), left_h: 16'(lh),
              right_x: 24'(rx), right_y: 24'(ry), right_w: 16'(rw), right_h: 16'(rh)};
        return p;
    endfunction

    // Items from the key pool; the low bytes collide to build probe chains.
    task automatic send_pool_items(int count);
        int k;
        repeat (count)
        begin
            k = $urandom_range(POOL_SIZE - 1);
            send_pair(random_geometry(pool_left[k], pool_right[k]));
        end
    endtask

    // Stimulus.
    initial
    begin
        pairs.valid  = 1'b0;
        pairs.data   = '0;
        rst_n        = 1'b0;
        send_idle    = 0;
        recv_stall   = 0;
        hold_request = 0;
        fresh_count  = 0;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pool_left[i]  = $urandom;
            pool_right[i] = {24'($urandom_range(32'hFF_FFFF)), 8'(i % 6)};
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: one key walks through enter, stay, exit and none.
        send_pair(shaped_pair(32'h1, 32'h2, KIND_RECT, KIND_RECT, 0, 0, 1, 1, 99, 0, 1, 1));
        send_pair(shaped_pair(32'h1, 32'h2, KIND_RECT, KIND_RECT, 0, 0, 1, 1, 0, 99, 1, 1));
        // A rectangle edge that only touches does not overlap.
        send_pair(shaped_pair(32'h1, 32'h2, KIND_RECT, KIND_RECT, 0, 0, 1, 1, 100, 0, 1, 1));
        send_pair(shaped_pair(32'h1, 32'h2, KIND_RECT, KIND_RECT, 0, 0, 1, 1, 100, 0, 1, 1));
        // New pair that misses is stored without contact.
        send_pair(shaped_pair(32'h3, 32'h4, KIND_CIRCLE, KIND_CIRCLE, 0, 0, 1, 1,
                              5000, 0, 1, 1));
        // Circles that just touch do overlap.
        send_pair(shaped_pair(32'h3, 32'h4, KIND_CIRCLE, KIND_CIRCLE, 0, 0, 1, 1, 100, 0, 1, 1));
        send_pair(shaped_pair(32'h3, 32'h4, KIND_CIRCLE, KIND_CIRCLE, 0, 0, 1, 1, 101, 0, 1, 1));
        // Circle against rectangle in both orders.
        send_pair(shaped_pair(32'h5, 32'h6, KIND_CIRCLE, KIND_RECT, 0, 0, 2, 2, 150, 0, 1, 1));
        send_pair(shaped_pair(32'h5, 32'h6, KIND_CIRCLE, KIND_RECT, 0, 0, 2, 2, 300, 300, 1, 1));
        send_pair(shaped_pair(32'h7, 32'h8, KIND_RECT, KIND_CIRCLE, 150, 0, 1, 1, 0, 0, 2, 2));
        send_pair(shaped_pair(32'h7, 32'h8, KIND_RECT, KIND_CIRCLE, 100, 100, 1, 1, 0, 0, 2, 2));
        // Other kinds never intersect, even fully coincident.
        send_pair(shaped_pair(32'h9, 32'hA, 2'd2, KIND_RECT, 0, 0, 9, 9, 0, 0, 9, 9));
        send_pair(shaped_pair(32'h9, 32'hA, KIND_CIRCLE, 2'd3, 0, 0, 9, 9, 0, 0, 9, 9));
        send_pair(shaped_pair(32'h9, 32'hA, 2'd3, 2'd2, 0, 0, 9, 9, 0, 0, 9, 9));
        // Extremes of positions, sizes and ids.
        send_pair(shaped_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, KIND_RECT, KIND_RECT,
                              -8388608, -8388608, 65535, 65535,
                              8388607, 8388607, 65535, 65535));
        send_pair(shaped_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, KIND_CIRCLE, KIND_CIRCLE,
                              8388607, -8388608, 65535, 0, -8388608, 8388607, 65535, 65535));
        send_pair(shaped_pair(32'h0, 32'h0, KIND_CIRCLE, KIND_RECT,
                              -8388608, 8388607, 65535, 65535, 8388607, -8388608, 0, 0));
        send_pair(shaped_pair(32'h0, 32'h0, KIND_RECT, KIND_CIRCLE,
                              0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(shaped_pair(32'h0, 32'h0, KIND_RECT, KIND_RECT, 0, 0, 0, 0, 0, 0, 0, 0));
        // Same low byte as an earlier key forces a second probe.
        send_pair(shaped_pair(32'h1, 32'h102, KIND_RECT, KIND_RECT, 0, 0, 5, 5, 0, 0, 5, 5));

        // Random phases over the key pool; the first has a long receiver hold-off.
        send_idle  = 0;
        recv_stall = 0;
        hold_request = 800;
        send_pool_items(230);
        send_idle  = 67;
        recv_stall = 0;
        send_pool_items(230);
        // Sender pause until every event has come back.
        pairs.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        send_idle  = 0;
        recv_stall = 67;
        send_pool_items(230);
        send_idle  = 12;
        recv_stall = 12;
        send_pool_items(230);

        // Fresh pairs fill the table, then new pairs overflow it.
        send_idle  = 0;
        recv_stall = 0;
        repeat (260)
        begin
            fresh_count++;
            send_pair(random_geometry(32'hF000_0000 + fresh_count, $urandom));
        end
        send_idle  = 12;
        recv_stall = 12;
        repeat (100)
        begin
            if ($urandom_range(1) == 0)
            begin
                fresh_count++;
                send_pair(random_geometry(32'hF000_0000 + fresh_count, $urandom));
            end
            else
            begin
                send_pool_items(1);
            end
        end

        // Drain and give the verdict.
        pairs.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
